// ===== hdl/vlr_pkg.sv =====
`timescale 1ns / 1ps

package vlr_pkg;

  localparam int FRAC_BITS      = 24;
  localparam int WORD_WIDTH     = 32;
  localparam int KCONST_WIDTH   = 31;
  localparam int DELTA_WIDTH    = 25;
  localparam int DIST_WIDTH     = 31;
  localparam int TAG_WIDTH      = 16;
  localparam int COMP_WIDTH     = 2;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 32;

  // internal arithmetic word, wide enough for every capped product and sum
  localparam int DW = 64;

  localparam logic [DW-1:0] MAG_CAP = 64'h1000_0000_0000_0000;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LIMITER_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LIMITER_CONSTANT = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SMALL_DELTA      = 2'd2;

  typedef logic signed [DW-1:0] dword_t;

  typedef struct packed {
    logic [TAG_WIDTH-1:0]         point_tag;
    logic [COMP_WIDTH-1:0]        component;
    logic signed [WORD_WIDTH-1:0] q_value;
    logic signed [WORD_WIDTH-1:0] grad_x;
    logic signed [WORD_WIDTH-1:0] grad_y;
    logic signed [WORD_WIDTH-1:0] q_max;
    logic signed [WORD_WIDTH-1:0] q_min;
    logic signed [WORD_WIDTH-1:0] offset_x;
    logic signed [WORD_WIDTH-1:0] offset_y;
    logic [DIST_WIDTH-1:0]        min_spacing;
  } in_item_t;

  typedef struct packed {
    logic [TAG_WIDTH-1:0]         tag_out;
    logic [COMP_WIDTH-1:0]        component_out;
    logic signed [WORD_WIDTH-1:0] recon_value;
    logic signed [WORD_WIDTH-1:0] limit_factor;
    logic                         saturated;
  } out_item_t;

  function automatic dword_t sext_word(input logic [WORD_WIDTH-1:0] x);
    return {{(DW-WORD_WIDTH){x[WORD_WIDTH-1]}}, x};
  endfunction

endpackage

// ===== hdl/vlr_mulq.sv =====
`timescale 1ns / 1ps

// Two-stage fixed-point multiply: (a*b) >> FRAC_BITS, magnitude truncated
// and capped at 2^60. Stage one forms four 32x32 partial products.
module vlr_mulq (
  input  logic           clk,
  input  logic           en,
  input  vlr_pkg::dword_t a,
  input  vlr_pkg::dword_t b,
  output vlr_pkg::dword_t p
);
  import vlr_pkg::*;

  localparam int HW = DW / 2;

  logic [DW-1:0]   ma, mb;
  logic [DW-1:0]   ll_r, lh_r, hl_r, hh_r;
  logic            neg_r;
  logic [2*DW-1:0] full, shifted;
  logic [DW-1:0]   capped;
  dword_t          p_r;

  assign ma = a[DW-1] ? (~a + 1'b1) : a;
  assign mb = b[DW-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= ma[HW-1:0] * mb[HW-1:0];
      lh_r  <= ma[HW-1:0] * mb[DW-1:HW];
      hl_r  <= ma[DW-1:HW] * mb[HW-1:0];
      hh_r  <= ma[DW-1:HW] * mb[DW-1:HW];
      neg_r <= a[DW-1] ^ b[DW-1];
    end
  end

  assign full    = {hh_r, ll_r} + ({{DW{1'b0}}, lh_r} << HW) + ({{DW{1'b0}}, hl_r} << HW);
  assign shifted = full >> FRAC_BITS;
  assign capped  = (shifted > {{DW{1'b0}}, MAG_CAP}) ? MAG_CAP : shifted[DW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_r ? dword_t'(~capped + 1'b1) : dword_t'(capped);
    end
  end

  assign p = p_r;

endmodule

// ===== hdl/venkat_limited_reconstruction.sv =====
`timescale 1ns / 1ps

// Venkatakrishnan-limited reconstruction of one state component per transaction.
// Input channel in_valid/in_stall/in_data carries one component of one point;
// the result channel out_valid/out_stall/out_data returns the limited value,
// the factor phi and a saturation flag, in input order, one per input.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; write
// only while the pipeline is empty.
// One transaction may enter every cycle while in_stall is low. The depth
// is set by the restoring divider for phi, one quotient bit per stage, plus
// the chain of four capped products that forms epsilon squared.
// Reset (synchronous, rst_n low) empties the pipeline and restores the
// registers: limiter on, K = 1.0, threshold 168.
// While out_valid is high and out_stall is high the whole pipeline holds and
// in_stall is raised; nothing is dropped or repeated.
module venkat_limited_reconstruction (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  vlr_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output vlr_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vlr_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [vlr_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import vlr_pkg::*;

  localparam int DIV_STEPS = WORD_WIDTH - 1;
  localparam int DIV_SHIFT = WORD_WIDTH - 1 - FRAC_BITS;
  localparam int TD        = 10 + DIV_STEPS;
  localparam int LAT       = TD + 4;

  localparam logic signed [WORD_WIDTH-1:0] PHI_ONE = WORD_WIDTH'(1) << FRAC_BITS;
  localparam logic signed [WORD_WIDTH-1:0] PHI_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [TAG_WIDTH-1:0]         tag;
    logic [COMP_WIDTH-1:0]        comp;
    logic signed [WORD_WIDTH-1:0] q;
  } side_t;

  typedef struct packed {
    logic use_div;
    logic sat;
    logic neg;
  } dflag_t;

  // configuration
  logic                    limiter_enable_r;
  logic [KCONST_WIDTH-1:0] limiter_constant_r;
  logic [DELTA_WIDTH-1:0]  small_delta_r;

  logic en;
  logic [LAT:1] vld_r;

  side_t                        side_r [1:LAT-1];
  logic signed [WORD_WIDTH-1:0] qmax_r [1:3];
  logic signed [WORD_WIDTH-1:0] qmin_r [1:3];
  dword_t                       s_r    [3:TD+1];
  dword_t                       kd_r   [3:4];

  dword_t pa, pb, kd, kd2, eps, e2, p2, b2, ab, pm;
  dword_t s_half, dq_mag;
  logic [DW-1:0] s_hsum;
  dword_t dq4_r, dmax_r, dmin_r, dp_r, dq5_r;
  logic [9:5] lim_r;
  dword_t p2_8_r, x8_r, y8_r, num_r, den_r;
  logic [DW-1:0] num_mag;

  logic [DW-1:0]        rem_r [0:DIV_STEPS];
  logic [DW-1:0]        dv_r  [0:DIV_STEPS];
  logic [DW-1:0]        nn_r  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] qq_r  [0:DIV_STEPS];
  dflag_t               dfl_r [0:DIV_STEPS];

  logic signed [WORD_WIDTH-1:0] phi_nxt;
  logic signed [WORD_WIDTH-1:0] phi_r [TD+1:TD+3];

  logic [DW-1:0] m_hsum;
  dword_t        m_half, r_full;
  out_item_t     out_nxt, out_r;

  assign en        = !(vld_r[LAT] && out_stall);
  assign in_stall  = vld_r[LAT] && out_stall;
  assign out_valid = vld_r[LAT];
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limiter_enable_r   <= 1'b1;
      limiter_constant_r <= KCONST_WIDTH'(16777216);
      small_delta_r      <= DELTA_WIDTH'(168);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LIMITER_ENABLE:   limiter_enable_r   <= cfg_data[0];
        CFG_LIMITER_CONSTANT: limiter_constant_r <= cfg_data[KCONST_WIDTH-1:0];
        CFG_SMALL_DELTA:      small_delta_r      <= cfg_data[DELTA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:1], in_valid};
    end
  end

  // products from the input ports: dx*gx, dy*gy, K*ds
  vlr_mulq u_mul_x (.clk(clk), .en(en), .a(sext_word(in_data.offset_x)),
                    .b(sext_word(in_data.grad_x)), .p(pa));
  vlr_mulq u_mul_y (.clk(clk), .en(en), .a(sext_word(in_data.offset_y)),
                    .b(sext_word(in_data.grad_y)), .p(pb));
  vlr_mulq u_mul_kd (.clk(clk), .en(en),
                     .a({{(DW-KCONST_WIDTH){1'b0}}, limiter_constant_r}),
                     .b({{(DW-DIST_WIDTH){1'b0}}, in_data.min_spacing}), .p(kd));

  // epsilon chain: kd^2, kd^3, eps^2
  vlr_mulq u_mul_kd2 (.clk(clk), .en(en), .a(kd), .b(kd), .p(kd2));
  vlr_mulq u_mul_eps (.clk(clk), .en(en), .a(kd2), .b(kd_r[4]), .p(eps));
  vlr_mulq u_mul_e2  (.clk(clk), .en(en), .a(eps), .b(eps), .p(e2));

  // limiter products
  vlr_mulq u_mul_p2 (.clk(clk), .en(en), .a(dp_r), .b(dp_r), .p(p2));
  vlr_mulq u_mul_b2 (.clk(clk), .en(en), .a(dq5_r), .b(dq5_r), .p(b2));
  vlr_mulq u_mul_ab (.clk(clk), .en(en), .a(dp_r), .b(dq5_r), .p(ab));

  // phi * S
  vlr_mulq u_mul_ps (.clk(clk), .en(en), .a(sext_word(phi_r[TD+1])), .b(s_r[TD+1]), .p(pm));

  // halve toward zero, then negate
  assign s_hsum = s_r[3] + {{(DW-1){1'b0}}, s_r[3][DW-1]};
  assign s_half = {s_hsum[DW-1], s_hsum[DW-1:1]};
  assign dq_mag = dq4_r[DW-1] ? (~dq4_r + 1'b1) : dq4_r;
  assign num_mag = num_r[DW-1] ? (~num_r + 1'b1) : num_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= '{tag: in_data.point_tag, comp: in_data.component, q: in_data.q_value};
      qmax_r[1] <= in_data.q_max;
      qmin_r[1] <= in_data.q_min;
      for (int i = 2; i <= LAT-1; i++) begin
        side_r[i] <= side_r[i-1];
      end
      for (int i = 2; i <= 3; i++) begin
        qmax_r[i] <= qmax_r[i-1];
        qmin_r[i] <= qmin_r[i-1];
      end

      s_r[3] <= pa + pb;
      for (int i = 4; i <= TD+1; i++) begin
        s_r[i] <= s_r[i-1];
      end
      kd_r[3] <= kd;
      kd_r[4] <= kd_r[3];

      dq4_r  <= ~s_half + 1'b1;
      dmax_r <= sext_word(qmax_r[3]) - sext_word(side_r[3].q);
      dmin_r <= sext_word(qmin_r[3]) - sext_word(side_r[3].q);

      dp_r     <= (!dq4_r[DW-1] && (dq4_r != '0)) ? dmax_r : dmin_r;
      dq5_r    <= dq4_r;
      lim_r[5] <= limiter_enable_r && (dq_mag > {{(DW-DELTA_WIDTH){1'b0}}, small_delta_r});
      for (int i = 6; i <= 9; i++) begin
        lim_r[i] <= lim_r[i-1];
      end

      p2_8_r <= p2;
      x8_r   <= ab <<< 1;
      y8_r   <= (b2 <<< 1) + ab;
      num_r  <= p2_8_r + e2 + x8_r;
      den_r  <= p2_8_r + e2 + y8_r;

      // divider set-up: saturate when |num| >= den * 2^(W-1-F)
      rem_r[0] <= num_mag >> DIV_SHIFT;
      dv_r[0]  <= den_r;
      nn_r[0]  <= num_mag;
      qq_r[0]  <= '0;
      dfl_r[0] <= '{use_div: lim_r[9] && !den_r[DW-1] && (den_r != '0) && (num_r < den_r),
                   sat: ({{DIV_SHIFT{1'b0}}, num_mag} >= {den_r, {DIV_SHIFT{1'b0}}}),
                   neg: num_r[DW-1]};
    end
  end

  // restoring division, one quotient bit per stage, most significant first
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    localparam int BI = DIV_STEPS - k;
    logic        nbit;
    logic [DW:0] trial;
    logic        fits;

    if (BI >= FRAC_BITS) begin : g_nb
      assign nbit = nn_r[k-1][BI-FRAC_BITS];
    end else begin : g_zb
      assign nbit = 1'b0;
    end

    assign trial = {rem_r[k-1], nbit};
    assign fits  = trial >= {1'b0, dv_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= fits ? DW'(trial - {1'b0, dv_r[k-1]}) : trial[DW-1:0];
        dv_r[k]  <= dv_r[k-1];
        nn_r[k]  <= nn_r[k-1];
        qq_r[k]  <= {qq_r[k-1][DIV_STEPS-2:0], fits};
        dfl_r[k] <= dfl_r[k-1];
      end
    end
  end

  always_comb begin
    if (!dfl_r[DIV_STEPS].use_div) begin
      phi_nxt = PHI_ONE;
    end else if (dfl_r[DIV_STEPS].sat) begin
      phi_nxt = PHI_MIN;
    end else if (dfl_r[DIV_STEPS].neg) begin
      phi_nxt = ~{1'b0, qq_r[DIV_STEPS]} + 1'b1;
    end else begin
      phi_nxt = {1'b0, qq_r[DIV_STEPS]};
    end
  end

  // final step: q - (phi*S)/2, clip to the word range
  assign m_hsum = pm + {{(DW-1){1'b0}}, pm[DW-1]};
  assign m_half = {m_hsum[DW-1], m_hsum[DW-1:1]};
  assign r_full = sext_word(side_r[LAT-1].q) - m_half;

  always_comb begin
    out_nxt.tag_out       = side_r[LAT-1].tag;
    out_nxt.component_out = side_r[LAT-1].comp;
    out_nxt.limit_factor  = phi_r[TD+3];
    if (!r_full[DW-1] && (r_full[DW-2:WORD_WIDTH-1] != '0)) begin
      out_nxt.recon_value = {1'b0, {(WORD_WIDTH-1){1'b1}}};
      out_nxt.saturated   = 1'b1;
    end else if (r_full[DW-1] && (r_full[DW-2:WORD_WIDTH-1] != '1)) begin
      out_nxt.recon_value = {1'b1, {(WORD_WIDTH-1){1'b0}}};
      out_nxt.saturated   = 1'b1;
    end else begin
      out_nxt.recon_value = r_full[WORD_WIDTH-1:0];
      out_nxt.saturated   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phi_r[TD+1] <= phi_nxt;
      phi_r[TD+2] <= phi_r[TD+1];
      phi_r[TD+3] <= phi_r[TD+2];
      out_r       <= out_nxt;
    end
  end

endmodule
